// ----- rtl/quadrature_decoder_with_rpm_core_defines.svh -----
// Assertion macros for the quadrature decoder core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef QUADRATURE_DECODER_WITH_RPM_CORE_DEFINES_SVH
`define QUADRATURE_DECODER_WITH_RPM_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define QDR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define QDR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qdr_pkg.sv -----
// Shared types and constants for the quadrature decoder core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package qdr_pkg;

  // operation codes
  localparam logic [1:0] OP_PIN   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SPEED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_CPR  = 2'd0;
  localparam logic [1:0] CFG_LREV = 2'd1;
  localparam logic [1:0] CFG_RREV = 2'd2;

  localparam logic [15:0] CPR_RESET       = 16'd140;
  localparam logic        LEFT_REV_RESET  = 1'b1;
  localparam logic        RIGHT_REV_RESET = 1'b0;

  // 60e6 * 256 = 3 * 2^32 + SPEED_K_LO
  localparam logic [31:0] SPEED_K_LO = 32'd2475098112;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int NUM_W     = 66;
  localparam int DIVCNT_W  = $clog2(NUM_W);

  typedef struct packed {
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic        is_speed;
    logic [31:0] dc;
    logic [31:0] dt;
  } qdr_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qdr_fifo_st_t;

  typedef struct packed {
    logic busy;
    logic out_is_speed;
  } qdr_back_st_t;

  // {up, down} for a 4-bit transition code {old_phase, new_phase}
  function automatic logic [1:0] step_of(input logic [3:0] code);
    logic [1:0] s;
    s = 2'b00;
    case (code)
      4'b0001, 4'b0111, 4'b1110, 4'b1000: s = 2'b10;
      4'b0010, 4'b0100, 4'b1101, 4'b1011: s = 2'b01;
      default:                            s = 2'b00;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/quadrature_decoder_with_rpm_core.sv -----
// Two-channel x4 quadrature decoder with rpm measurement, top level.
// Input stream: in_tuser = operation and channel select, in_tdata = pins and
// timestamp. Output stream: out_tdata holds left count, right count, rpm.
// Pin samples and clears stream one per clock while the output is not stalled
// and no speed read is in progress; the result is presented on out_* right
// after the edge where the item leaves the queue.
// A speed read with a nonzero interval runs through the rpm unit: a multiply
// state and an add state, then a restoring divider that retires one quotient
// bit per cycle. Items behind it keep being accepted until the four-entry
// queue fills.
// The output register holds a result until out_tready; the queue decouples
// the decoders from the stall, so in_tready only drops when the queue is full.
// Reset (rst_n low, synchronous) zeroes counts, phases and speed history,
// empties the queue and loads 140 ticks per revolution, left reverse set,
// right reverse clear. cfg_* writes land at the clock edge where cfg_we is high.
// Depends on qdr_pkg and the defines header.
`timescale 1ns / 1ps
`include "quadrature_decoder_with_rpm_core_defines.svh"

module quadrature_decoder_with_rpm_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // pin_a, pin_b, pin_c, pin_d, now_us[31:0], pad
  input  logic [2:0]  in_tuser,  // operation[1:0], which_encoder
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata, // left_count, right_count, speed_rpm_q8
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import qdr_pkg::*;

  logic [15:0]  cpr_r;
  logic         lrev_r, rrev_r;
  logic         fifo_push, fifo_pop;
  qdr_entry_t   wr_entry, rd_entry;
  qdr_fifo_st_t fifo_st;
  qdr_back_st_t bk_st;
  logic [31:0]  left_count, right_count, speed_rpm_q8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r  <= CPR_RESET;
      lrev_r <= LEFT_REV_RESET;
      rrev_r <= RIGHT_REV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CPR:  cpr_r  <= cfg_data;
        CFG_LREV: lrev_r <= cfg_data[0];
        CFG_RREV: rrev_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  qdr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .operation     (in_tuser[1:0]),
    .pins          (in_tdata[3:0]),
    .which_encoder (in_tuser[2]),
    .now_us        (in_tdata[35:4]),
    .left_reverse  (lrev_r),
    .right_reverse (rrev_r),
    .fifo_full     (fifo_st.full),
    .push          (fifo_push),
    .entry         (wr_entry)
  );

  qdr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .wr_entry (wr_entry),
    .pop      (fifo_pop),
    .rd_entry (rd_entry),
    .status   (fifo_st)
  );

  qdr_rpm u_rpm (
    .clk           (clk),
    .rst_n         (rst_n),
    .entry         (rd_entry),
    .fifo_empty    (fifo_st.empty),
    .pop           (fifo_pop),
    .ticks_per_rev (cpr_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .left_count    (left_count),
    .right_count   (right_count),
    .speed_rpm_q8  (speed_rpm_q8),
    .status        (bk_st)
  );

  assign out_tdata = {speed_rpm_q8, right_count, left_count};

  `QDR_ASSERT_IMP(a_push_not_full, fifo_push, !fifo_st.full, "push into full queue")
  `QDR_ASSERT_IMP(a_pop_not_empty, fifo_pop, !fifo_st.empty, "pop from empty queue")
  `QDR_ASSERT_IMP(a_pop_when_idle, fifo_pop, !bk_st.busy, "pop while rpm unit busy")
  `QDR_ASSERT_NXT(a_plain_item_out, fifo_pop && !rd_entry.is_speed, out_tvalid, "plain item not presented")
  `QDR_ASSERT_IMP(a_plain_speed_zero, out_tvalid && !bk_st.out_is_speed, out_tdata[95:64] == 32'd0, "nonzero rpm on plain item")

endmodule

// ----- rtl/qdr_front.sv -----
// Front end: accepts items, runs both x4 decoders and the speed bookkeeping.
// Depends on qdr_pkg; pushes one entry per item into the queue.
`timescale 1ns / 1ps

module qdr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [3:0]          pins,
  input  logic                which_encoder,
  input  logic [31:0]         now_us,
  input  logic                left_reverse,
  input  logic                right_reverse,
  input  logic                fifo_full,
  output logic                push,
  output qdr_pkg::qdr_entry_t entry
);
  import qdr_pkg::*;

  logic [31:0] lpos_r, rpos_r, lpp_r, rpp_r, lpt_r, rpt_r;
  logic [1:0]  lph_r, rph_r;
  logic [31:0] lpos_nxt, rpos_nxt, lpp_nxt, rpp_nxt, lpt_nxt, rpt_nxt;
  logic [1:0]  lph_nxt, rph_nxt;
  logic [1:0]  lstep, rstep;
  logic [31:0] sel_pos, sel_pp, sel_pt, dt, dc;
  logic        accept;

  assign in_ready = !fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign push     = accept;

  // pins = {pin_d, pin_c, pin_b, pin_a}; a phase is {A, B}
  assign lstep = step_of({lph_r, pins[0], pins[1]});
  assign rstep = step_of({rph_r, pins[2], pins[3]});

  assign sel_pos = which_encoder ? rpos_r : lpos_r;
  assign sel_pp  = which_encoder ? rpp_r  : lpp_r;
  assign sel_pt  = which_encoder ? rpt_r  : lpt_r;
  assign dt      = now_us - sel_pt;
  assign dc      = sel_pos - sel_pp;

  always_comb begin
    lpos_nxt = lpos_r;
    rpos_nxt = rpos_r;
    lph_nxt  = lph_r;
    rph_nxt  = rph_r;
    lpp_nxt  = lpp_r;
    rpp_nxt  = rpp_r;
    lpt_nxt  = lpt_r;
    rpt_nxt  = rpt_r;
    unique case (operation)
      OP_PIN: begin
        lph_nxt = {pins[0], pins[1]};
        rph_nxt = {pins[2], pins[3]};
        if (lstep[1] ^ left_reverse ^ 1'b0 && |lstep) begin
          lpos_nxt = lpos_r + 32'd1;
        end else if (|lstep) begin
          lpos_nxt = lpos_r - 32'd1;
        end
        if (rstep[1] ^ right_reverse && |rstep) begin
          rpos_nxt = rpos_r + 32'd1;
        end else if (|rstep) begin
          rpos_nxt = rpos_r - 32'd1;
        end
      end
      OP_CLEAR: begin
        lpos_nxt = '0;
        rpos_nxt = '0;
      end
      OP_SPEED: begin
        if (dt != '0) begin
          if (which_encoder) begin
            rpp_nxt = rpos_r;
            rpt_nxt = now_us;
          end else begin
            lpp_nxt = lpos_r;
            lpt_nxt = now_us;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    entry.left_count  = lpos_nxt;
    entry.right_count = rpos_nxt;
    entry.is_speed    = (operation == OP_SPEED) && (dt != '0);
    entry.dc          = dc;
    entry.dt          = dt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpos_r <= '0;
      rpos_r <= '0;
      lph_r  <= '0;
      rph_r  <= '0;
      lpp_r  <= '0;
      rpp_r  <= '0;
      lpt_r  <= '0;
      rpt_r  <= '0;
    end else if (accept) begin
      lpos_r <= lpos_nxt;
      rpos_r <= rpos_nxt;
      lph_r  <= lph_nxt;
      rph_r  <= rph_nxt;
      lpp_r  <= lpp_nxt;
      rpp_r  <= rpp_nxt;
      lpt_r  <= lpt_nxt;
      rpt_r  <= rpt_nxt;
    end
  end

endmodule

// ----- rtl/qdr_fifo.sv -----
// Short queue between the decoder front end and the speed back end.
// Depends on qdr_pkg for the entry type and depth.
`timescale 1ns / 1ps

module qdr_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  qdr_pkg::qdr_entry_t   wr_entry,
  input  logic                  pop,
  output qdr_pkg::qdr_entry_t   rd_entry,
  output qdr_pkg::qdr_fifo_st_t status
);
  import qdr_pkg::*;

  qdr_entry_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r;
  logic               do_push, do_pop;

  assign status.full  = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_entry     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/qdr_rpm.sv -----
// Back end: rpm computation (multiply, then restoring divide one bit a cycle)
// and the output register. Depends on qdr_pkg.
`timescale 1ns / 1ps

module qdr_rpm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  qdr_pkg::qdr_entry_t   entry,
  input  logic                  fifo_empty,
  output logic                  pop,
  input  logic [15:0]           ticks_per_rev,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           left_count,
  output logic [31:0]           right_count,
  output logic [31:0]           speed_rpm_q8,
  output qdr_pkg::qdr_back_st_t status
);
  import qdr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state_r;
  logic [DIVCNT_W-1:0] cnt_r;
  logic                neg_r, big_r;
  logic [31:0]         m_r, dt_r, hold_l_r, hold_r_r;
  logic [63:0]         prod_r;
  logic [33:0]         m3_r;
  logic [47:0]         d_r, rem_r;
  logic [NUM_W-1:0]    num_r;
  logic [32:0]         q_r;
  logic                out_valid_r, out_is_speed_r;
  logic [31:0]         out_l_r, out_rc_r, out_s_r;

  logic                out_free, out_load, q_bit, ovf;
  logic [15:0]         cpr_eff;
  logic [48:0]         rem_sh, rem_sub;
  logic [31:0]         m_abs, sat;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == ST_IDLE) && !fifo_empty && out_free;
  // output register takes a plain item on pop or a finished speed read
  assign out_load = (pop && !entry.is_speed) || ((state_r == ST_DONE) && out_free);
  assign cpr_eff  = (ticks_per_rev == '0) ? 16'd1 : ticks_per_rev;
  // magnitude of the count delta; the most negative value maps onto itself
  assign m_abs    = entry.dc[31] ? (~entry.dc + 32'd1) : entry.dc;

  assign rem_sh   = {rem_r, num_r[NUM_W-1]};
  assign rem_sub  = rem_sh - {1'b0, d_r};
  assign q_bit    = (rem_sh >= {1'b0, d_r});

  assign ovf = big_r || q_r[32] || q_r[31];
  always_comb begin
    if (neg_r) begin
      sat = ovf ? 32'h8000_0000 : (~q_r[31:0] + 32'd1);
    end else begin
      sat = ovf ? 32'h7FFF_FFFF : q_r[31:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign left_count   = out_l_r;
  assign right_count  = out_rc_r;
  assign speed_rpm_q8 = out_s_r;
  assign status.busy         = (state_r != ST_IDLE);
  assign status.out_is_speed = out_is_speed_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      unique case (state_r)
        ST_IDLE: begin
          if (pop && entry.is_speed) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: state_r <= ST_ADD;
        ST_ADD: begin
          state_r <= ST_DIV;
          cnt_r   <= DIVCNT_W'(NUM_W - 1);
        end
        ST_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          hold_l_r <= entry.left_count;
          hold_r_r <= entry.right_count;
          neg_r    <= entry.dc[31];
          m_r      <= m_abs;
          dt_r     <= entry.dt;
          if (!entry.is_speed) begin
            out_l_r        <= entry.left_count;
            out_rc_r       <= entry.right_count;
            out_s_r        <= '0;
            out_is_speed_r <= 1'b0;
          end
        end
      end
      ST_MUL: begin
        prod_r <= 64'(m_r) * 64'(SPEED_K_LO);
        m3_r   <= {2'b00, m_r} + {1'b0, m_r, 1'b0};
        d_r    <= 48'(cpr_eff) * 48'(dt_r);
      end
      ST_ADD: begin
        num_r <= {2'b00, prod_r} + {m3_r, 32'd0};
        rem_r <= '0;
        q_r   <= '0;
        big_r <= 1'b0;
      end
      ST_DIV: begin
        rem_r <= q_bit ? rem_sub[47:0] : rem_sh[47:0];
        q_r   <= {q_r[31:0], q_bit};
        // quotient bits at weight 2^33 and up only matter as overflow
        big_r <= big_r | q_r[32];
        num_r <= {num_r[NUM_W-2:0], 1'b0};
      end
      ST_DONE: begin
        if (out_free) begin
          out_l_r        <= hold_l_r;
          out_rc_r       <= hold_r_r;
          out_s_r        <= sat;
          out_is_speed_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/tb_quadrature_decoder_with_rpm_core.sv -----
// Self-checking testbench for quadrature_decoder_with_rpm_core: x4 decoding, clears,
// rpm reads and config registers, with random stalls on both streams.
// Needs qdr_pkg and the core RTL; no files or arguments.
`timescale 1ns / 1ps

module tb_quadrature_decoder_with_rpm_core;
  import qdr_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [65:0] RPM_SCALE      = 66'd15360000000;  // 60e6 us/min * 256
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          TAIL_CYCLES    = 100;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic [31:0] speed_rpm_q8;
  } wheel_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // pin_a, pin_b, pin_c, pin_d, now_us[31:0], pad
  logic [2:0]  in_tuser = '0;  // operation[1:0], which_encoder
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;      // left_count, right_count, speed_rpm_q8
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  quadrature_decoder_with_rpm_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // decoder shadow state, index 0 = left wheel, 1 = right wheel
  logic [31:0] wheel_pos [2];
  logic [1:0]  wheel_phase [2];
  logic [31:0] mark_pos [2];
  logic [31:0] mark_us [2];
  logic        reverse_cfg [2];
  logic [15:0] cpr_cfg;

  wheel_report_t pending_reports [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  // stimulus controls
  bit          sender_gaps = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          long_hold_req = 1'b0;
  bit          holding = 1'b0;
  logic [1:0]  walk_pos [2];
  int          walk_dir [2];
  logic [31:0] sim_us = '0;
  logic [31:0] last_read_us [2];

  // +1 / -1 / 0 from the move around the gray cycle 00 -> 01 -> 11 -> 10
  function automatic int quad_step(input logic [1:0] from_ph, input logic [1:0] to_ph);
    logic [1:0] turn;
    turn = {to_ph[1], ^to_ph} - {from_ph[1], ^from_ph};
    if (turn == 2'd1) return 1;
    if (turn == 2'd3) return -1;
    return 0;
  endfunction

  function automatic logic [31:0] rpm_q8_of(input logic [31:0] dcount, input logic [31:0] dus,
                                            input logic [15:0] cpr);
    logic        neg;
    logic [65:0] mag, den, quo;
    neg = dcount[31];
    mag = {34'd0, neg ? (~dcount + 32'd1) : dcount};
    den = {50'd0, (cpr == 16'd0) ? 16'd1 : cpr} * {34'd0, dus};
    quo = (mag * RPM_SCALE) / den;
    if (neg) return (quo >= 66'h80000000) ? 32'h80000000 : (~quo[31:0] + 32'd1);
    return (quo > 66'h7FFFFFFF) ? 32'h7FFFFFFF : quo[31:0];
  endfunction

  task automatic model_reset;
    for (int ch = 0; ch < 2; ch++) begin
      wheel_pos[ch] = '0;
      wheel_phase[ch] = '0;
      mark_pos[ch] = '0;
      mark_us[ch] = '0;
      walk_pos[ch] = '0;
      walk_dir[ch] = 1;
      last_read_us[ch] = '0;
    end
    cpr_cfg = CPR_RESET;
    reverse_cfg[0] = LEFT_REV_RESET;
    reverse_cfg[1] = RIGHT_REV_RESET;
  endtask

  task automatic predict_report(input logic [1:0] op, input logic [3:0] pins, input logic sel,
                                input logic [31:0] now, output wheel_report_t rep);
    logic [1:0]  new_ph [2];
    logic [31:0] span, delta;
    int          s;
    rep.speed_rpm_q8 = '0;
    new_ph[0] = {pins[0], pins[1]};
    new_ph[1] = {pins[2], pins[3]};
    case (op)
      OP_PIN: begin
        for (int ch = 0; ch < 2; ch++) begin
          s = quad_step(wheel_phase[ch], new_ph[ch]);
          if (reverse_cfg[ch]) s = -s;
          if (s > 0) wheel_pos[ch] = wheel_pos[ch] + 32'd1;
          else if (s < 0) wheel_pos[ch] = wheel_pos[ch] - 32'd1;
          wheel_phase[ch] = new_ph[ch];
        end
      end
      OP_CLEAR: begin
        wheel_pos[0] = '0;
        wheel_pos[1] = '0;
      end
      OP_SPEED: begin
        span = now - mark_us[sel];
        if (span != 32'd0) begin
          delta = wheel_pos[sel] - mark_pos[sel];
          mark_pos[sel] = wheel_pos[sel];
          mark_us[sel] = now;
          rep.speed_rpm_q8 = rpm_q8_of(delta, span, cpr_cfg);
        end
      end
      default: ;
    endcase
    rep.left_count = wheel_pos[0];
    rep.right_count = wheel_pos[1];
  endtask

  // predict at the accepting edge
  always @(posedge clk) begin : input_monitor
    wheel_report_t rep;
    if (rst_n && in_tvalid && in_tready) begin
      predict_report(in_tuser[1:0], in_tdata[3:0], in_tuser[2], in_tdata[35:4], rep);
      pending_reports.push_back(rep);
    end
  end

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin : result_check
    wheel_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("unexpected transaction", '0, out_tdata[31:0]);
      end else begin
        want = pending_reports.pop_front();
        if (out_tdata[31:0] !== want.left_count)
          flag_mismatch("left_count", want.left_count, out_tdata[31:0]);
        if (out_tdata[63:32] !== want.right_count)
          flag_mismatch("right_count", want.right_count, out_tdata[63:32]);
        if (out_tdata[95:64] !== want.speed_rpm_q8)
          flag_mismatch("speed_rpm_q8", want.speed_rpm_q8, out_tdata[95:64]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : receiver
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        holding = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // pins nibble is {pin_d, pin_c, pin_b, pin_a}; a phase is {A, B}
  function automatic logic [3:0] pins_for(input logic [1:0] lph, input logic [1:0] rph);
    return {rph[0], rph[1], lph[0], lph[1]};
  endfunction

  function automatic logic [1:0] gray_of(input logic [1:0] p);
    return {p[1], p[1] ^ p[0]};
  endfunction

  task automatic send_item(input logic [1:0] op, input logic [3:0] pins, input logic sel,
                           input logic [31:0] now);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {sel, op};
    in_tdata <= {4'd0, now, pins};
    if (op == OP_SPEED) last_read_us[sel] = now;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_pins(input logic [1:0] lph, input logic [1:0] rph, input logic [31:0] now);
    send_item(OP_PIN, pins_for(lph, rph), 1'b0, now);
  endtask

  task automatic read_speed(input logic sel, input logic [31:0] now);
    send_item(OP_SPEED, 4'hA, sel, now);
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_CPR:  cpr_cfg = value;
      CFG_LREV: reverse_cfg[0] = value[0];
      CFG_RREV: reverse_cfg[1] = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [15:0] cpr, input logic lrev, input logic rrev);
    drain_results();
    write_reg(CFG_CPR, cpr);
    write_reg(CFG_LREV, {15'd0, lrev});
    write_reg(CFG_RREV, {15'd0, rrev});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(input int count);
    int          pick, roll, k;
    logic [1:0]  op;
    logic [3:0]  pins;
    logic        sel;
    logic [31:0] stamp;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      pins = 4'($urandom_range(0, 15));
      sel = 1'($urandom_range(0, 1));
      stamp = $urandom;
      if (pick < 78) begin
        op = OP_PIN;
        for (int ch = 0; ch < 2; ch++) begin
          roll = $urandom_range(0, 39);
          if (roll == 0) walk_dir[ch] = -walk_dir[ch];
          if (roll < 28) walk_pos[ch] = walk_pos[ch] + 2'(walk_dir[ch]);
          else if (roll < 32) walk_pos[ch] = walk_pos[ch] - 2'(walk_dir[ch]);
          else if (roll >= 36) walk_pos[ch] = 2'($urandom_range(0, 3));  // noise, jumps
        end
        pins = pins_for(gray_of(walk_pos[0]), gray_of(walk_pos[1]));
      end else if (pick < 81) begin
        op = OP_CLEAR;
      end else if (pick < 96) begin
        op = OP_SPEED;
        k = $urandom_range(0, 19);
        if (k == 0) begin
          stamp = last_read_us[sel];  // zero interval
        end else begin
          if (k <= 2) sim_us = sim_us + 32'($urandom_range(1, 3));
          else if (k == 3) sim_us = $urandom;
          else sim_us = sim_us + 32'($urandom_range(50, 20000));
          stamp = sim_us;
        end
      end else begin
        op = OP_UNUSED;
      end
      send_item(op, pins, sel, stamp);
    end
  endtask

  // reset defaults: left reversed, right forward
  task automatic test_pin_decoding;
    send_pins(2'b00, 2'b00, 32'h0);
    send_pins(2'b01, 2'b01, 32'hFFFFFFFF);
    send_pins(2'b11, 2'b11, 32'h0);
    send_pins(2'b10, 2'b10, 32'h0);
    send_pins(2'b00, 2'b00, 32'h0);
    send_pins(2'b10, 2'b10, 32'h0);
    send_pins(2'b11, 2'b11, 32'h0);
    send_pins(2'b00, 2'b00, 32'h0);   // double jump
    send_pins(2'b11, 2'b01, 32'h0);
    send_item(OP_UNUSED, 4'hF, 1'b1, 32'hFFFFFFFF);
    send_item(OP_CLEAR, 4'h0, 1'b0, 32'h0);
  endtask

  task automatic test_speed_reads;
    apply_config(16'd1, 1'b1, 1'b0);
    read_speed(1'b0, 32'd0);            // zero interval since reset
    send_pins(2'b10, 2'b11, 32'h0);
    read_speed(1'b0, 32'd1);            // saturates negative
    read_speed(1'b1, 32'd1);            // saturates positive
    read_speed(1'b1, 32'd1);            // zero interval
    read_speed(1'b1, 32'hFFFFFFFF);
    send_pins(2'b00, 2'b10, 32'h0);
    read_speed(1'b0, 32'hFFFFFFFF);
    send_item(OP_CLEAR, 4'hF, 1'b1, 32'hFFFFFFFF);  // history survives the clear
    read_speed(1'b1, 32'd1000);         // interval wraps
    apply_config(16'd0, 1'b1, 1'b0);    // zero cpr acts as one
    send_pins(2'b01, 2'b11, 32'h0);
    read_speed(1'b0, 32'h80000000);
  endtask

  task automatic test_config_phases;
    apply_config(CPR_RESET, LEFT_REV_RESET, RIGHT_REV_RESET);
    random_items(170);
    apply_config(16'd1, 1'b0, 1'b1);
    random_items(170);
    apply_config(16'hFFFF, 1'b1, 1'b1);
    random_items(170);
    apply_config(16'd0, 1'b0, 1'b0);
    random_items(150);
    apply_config(16'($urandom_range(1, 2000)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    random_items(150);
  endtask

  // receiver holds off while items keep coming, so the queue fills
  task automatic test_output_backpressure;
    sender_gaps = 1'b0;
    long_hold_req = 1'b1;
    wait (holding);
    random_items(36);
    sender_gaps = 1'b1;
  endtask

  task automatic test_back_to_back;
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    random_items(80);
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_pin_decoding();
    test_speed_reads();
    test_config_phases();
    test_output_backpressure();
    test_back_to_back();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
